@@ rtl/stp_pkg.sv @@
// ----------------------------------------------------------------------------
// stp_pkg
// Shared types and constants for the scope trigger resampler.
// ----------------------------------------------------------------------------
package stp_pkg;

  // Store geometry and display size
  localparam int BUFFER_DEPTH = 1024;
  localparam int POINTS       = 256;
  localparam int HEIGHT       = 256;

  localparam int ADDR_W     = $clog2(BUFFER_DEPTH);
  localparam int SAMPLE_W   = 16;
  localparam int POINT_W    = 8;
  localparam int ROW_W      = 8;
  localparam int STEP_W     = 32;
  localparam int STEP_FRAC  = 16;
  localparam int ACTION_W   = 2;

  // HEIGHT is a power of two, so scaling by HALF_ROW / 32768 is an
  // arithmetic shift right, which floors as required.
  localparam int HALF_ROW   = HEIGHT / 2;
  localparam int ROW_SHIFT  = (SAMPLE_W - 1) - $clog2(HALF_ROW);
  localparam int ROW_MAX    = (1 << ROW_W) - 1;
  localparam int HALF_CLAMP = (HALF_ROW > ROW_MAX) ? ROW_MAX : HALF_ROW;

  localparam logic [STEP_W-1:0] STEP_RESET = 32'h0001_0000;

  typedef enum logic [ACTION_W-1:0] {
    ACT_LOAD   = 2'd0,
    ACT_SEARCH = 2'd1,
    ACT_POINT  = 2'd2,
    ACT_NONE   = 2'd3
  } action_t;

  localparam logic KIND_SEARCH = 1'b0;
  localparam logic KIND_POINT  = 1'b1;

  typedef struct packed {
    logic              kind;
    logic [ADDR_W-1:0] trig_pos;
    logic              edge_found;
    logic [ROW_W-1:0]  row;
  } stp_result_t;

endpackage

@@ rtl/stp_store.sv @@
// ----------------------------------------------------------------------------
// stp_store
// Sample memory with a circular write pointer and a registered read port.
// ----------------------------------------------------------------------------
module stp_store (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         wr_en,
  input  logic [stp_pkg::SAMPLE_W-1:0] wr_data,
  input  logic                         rd_en,
  input  logic [stp_pkg::ADDR_W-1:0]   rd_addr,
  output logic [stp_pkg::SAMPLE_W-1:0] rd_data
);
  import stp_pkg::*;

  logic [SAMPLE_W-1:0] mem [BUFFER_DEPTH];
  logic [SAMPLE_W-1:0] rd_q_r;
  logic                rd_ok_r;
  logic [ADDR_W-1:0]   wr_pos_r, wr_pos_nxt;
  logic                wrapped_r, wrapped_nxt;

  // Entries are filled strictly in address order, so an entry has been
  // written once the pointer has passed it or has wrapped at least once.
  // Reads of anything else return zero.
  always_comb begin
    wr_pos_nxt  = wr_pos_r;
    wrapped_nxt = wrapped_r;
    if (wr_en) begin
      wr_pos_nxt = wr_pos_r + 1'b1;
      if (wr_pos_r == ADDR_W'(BUFFER_DEPTH - 1)) begin
        wr_pos_nxt  = '0;
        wrapped_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_pos_r  <= '0;
      wrapped_r <= 1'b0;
    end else begin
      wr_pos_r  <= wr_pos_nxt;
      wrapped_r <= wrapped_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_pos_r] <= wr_data;
    end
    if (rd_en) begin
      rd_q_r  <= mem[rd_addr];
      rd_ok_r <= wrapped_r || (rd_addr < wr_pos_r);
    end
  end

  assign rd_data = rd_ok_r ? rd_q_r : '0;

endmodule

@@ rtl/stp_engine.sv @@
// ----------------------------------------------------------------------------
// stp_engine
// Sequencer for loads, the trigger search walk and the point lookup, with
// one shift-and-add unit forming the point offset a bit per cycle.
// ----------------------------------------------------------------------------
module stp_engine (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [stp_pkg::ACTION_W-1:0] action,
  input  logic [stp_pkg::SAMPLE_W-1:0] sample,
  input  logic [stp_pkg::POINT_W-1:0]  point_index,
  input  logic [stp_pkg::STEP_W-1:0]   point_step,
  output logic                         idle,
  output logic                         wr_en,
  output logic [stp_pkg::SAMPLE_W-1:0] wr_data,
  output logic                         rd_en,
  output logic [stp_pkg::ADDR_W-1:0]   rd_addr,
  input  logic [stp_pkg::SAMPLE_W-1:0] rd_data,
  output logic                         res_valid,
  input  logic                         res_ready,
  output stp_pkg::stp_result_t         res
);
  import stp_pkg::*;

  localparam int CNT_W = ADDR_W + 1;
  localparam int ACC_W = STEP_FRAC + ADDR_W;
  localparam int BIT_W = $clog2(POINT_W);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SRCH,
    S_MUL,
    S_READ,
    S_ROW,
    S_DONE
  } state_t;

  state_t              state_r, state_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [SAMPLE_W-1:0] prev_r, prev_nxt;
  logic [ADDR_W-1:0]   trig_idx_r, trig_idx_nxt;
  logic                trig_ok_r, trig_ok_nxt;
  logic [POINT_W-1:0]  k_r, k_nxt;
  logic [BIT_W-1:0]    bit_r, bit_nxt;
  logic [ACC_W-1:0]    acc_r, acc_nxt;
  stp_result_t         res_r, res_nxt;

  logic                cur_pos, prev_neg, crossing;
  logic [ACC_W-1:0]    addend;
  logic [SAMPLE_W-1:0] scaled;
  logic [SAMPLE_W-1:0] row_full;

  assign cur_pos  = !rd_data[SAMPLE_W-1] && (rd_data != '0);
  assign prev_neg = prev_r[SAMPLE_W-1];
  assign crossing = (cnt_r >= CNT_W'(2)) && prev_neg && cur_pos;

  // Multiplier bits are taken from the top down, so the accumulator
  // doubles before each add.
  assign addend = k_r[POINT_W-1 - bit_r] ? point_step[ACC_W-1:0] : '0;
  assign scaled = $signed(rd_data) >>> ROW_SHIFT;
  assign row_full = scaled + SAMPLE_W'(HALF_ROW);

  always_comb begin
    state_nxt    = state_r;
    cnt_nxt      = cnt_r;
    prev_nxt     = prev_r;
    trig_idx_nxt = trig_idx_r;
    trig_ok_nxt  = trig_ok_r;
    k_nxt        = k_r;
    bit_nxt      = bit_r;
    acc_nxt      = acc_r;
    res_nxt      = res_r;
    wr_en        = 1'b0;
    rd_en        = 1'b0;
    rd_addr      = cnt_r[ADDR_W-1:0];

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          case (action)
            ACT_LOAD: begin
              wr_en = 1'b1;
            end
            ACT_SEARCH: begin
              cnt_nxt   = '0;
              state_nxt = S_SRCH;
            end
            ACT_POINT: begin
              k_nxt          = point_index;
              bit_nxt        = '0;
              acc_nxt        = '0;
              res_nxt.kind       = KIND_POINT;
              res_nxt.trig_pos   = trig_idx_r;
              res_nxt.edge_found = trig_ok_r;
              res_nxt.row        = ROW_W'(HALF_CLAMP);
              if (trig_ok_r && ({1'b0, point_index} < (POINT_W + 1)'(POINTS))) begin
                state_nxt = S_MUL;
              end else begin
                state_nxt = S_DONE;
              end
            end
            default: begin
            end
          endcase
        end
      end

      S_SRCH: begin
        // Read address runs one ahead of the data; prev holds the sample
        // before the one now arriving.
        rd_en    = !cnt_r[ADDR_W];
        prev_nxt = rd_data;
        cnt_nxt  = cnt_r + 1'b1;
        res_nxt.kind = KIND_SEARCH;
        res_nxt.row  = '0;
        if (crossing) begin
          trig_idx_nxt       = ADDR_W'(cnt_r - CNT_W'(2));
          trig_ok_nxt        = 1'b1;
          res_nxt.trig_pos   = ADDR_W'(cnt_r - CNT_W'(2));
          res_nxt.edge_found = 1'b1;
          state_nxt          = S_DONE;
        end else if (cnt_r[ADDR_W]) begin
          trig_idx_nxt       = '0;
          trig_ok_nxt        = 1'b0;
          res_nxt.trig_pos   = '0;
          res_nxt.edge_found = 1'b0;
          state_nxt          = S_DONE;
        end
      end

      S_MUL: begin
        acc_nxt = {acc_r[ACC_W-2:0], 1'b0} + addend;
        bit_nxt = bit_r + 1'b1;
        if (bit_r == BIT_W'(POINT_W - 1)) begin
          state_nxt = S_READ;
        end
      end

      S_READ: begin
        rd_en     = 1'b1;
        rd_addr   = trig_idx_r + acc_r[STEP_FRAC +: ADDR_W];
        state_nxt = S_ROW;
      end

      S_ROW: begin
        res_nxt.row = row_full[ROW_W-1:0];
        state_nxt   = S_DONE;
      end

      S_DONE: begin
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      trig_idx_r <= '0;
      trig_ok_r  <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      trig_idx_r <= trig_idx_nxt;
      trig_ok_r  <= trig_ok_nxt;
    end
    cnt_r  <= cnt_nxt;
    prev_r <= prev_nxt;
    k_r    <= k_nxt;
    bit_r  <= bit_nxt;
    acc_r  <= acc_nxt;
    res_r  <= res_nxt;
  end

  assign idle      = (state_r == S_IDLE);
  assign wr_data   = sample;
  assign res_valid = (state_r == S_DONE);
  assign res       = res_r;

endmodule

@@ rtl/scope_trigger_resampler_top.sv @@
// ----------------------------------------------------------------------------
// scope_trigger_resampler_top
// Oscilloscope display engine: sample store, rising zero-crossing trigger
// search and resampled display point lookup.
// ----------------------------------------------------------------------------
//  Channel  Direction  Handshake              Content
//  in_      slave      in_tvalid/in_tready    tuser action, tdata sample/point
//  out_     master     out_tvalid/out_tready  tuser kind, tdata trigger/row
//  cfg_     slave      cfg_valid/cfg_ready    point_step, unsigned 16.16
//
// Loads stream at one per cycle. A search walks the store through its
// single read port, one sample a cycle. With a trigger found, a point
// request forms the shift-and-add offset, reads the memory, forms the row
// and hands the result on; without one, it hands on the mid-row result.
// No clearing pass follows reset; a fill count stands in for it. A result
// waits in the output register while the next item is taken; the engine
// stalls only if a second result is ready before the first has gone.
module scope_trigger_resampler_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // sample[15:0], point_index[23:16]
  input  logic [1:0]  in_tuser,   // action[1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // trigger_position[9:0], edge_found[10],
                                  // row_position[18:11], zero fill above
  output logic [0:0]  out_tuser,  // result_kind[0]
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] cfg_data
);
  import stp_pkg::*;

  logic [STEP_W-1:0]   step_r;
  logic                eng_idle;
  logic                wr_en, rd_en;
  logic [SAMPLE_W-1:0] wr_data, rd_data;
  logic [ADDR_W-1:0]   rd_addr;
  logic                res_valid, res_ready;
  stp_result_t         res;
  stp_result_t         out_r;
  logic                out_valid_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= STEP_RESET;
    end else if (cfg_valid && cfg_ready) begin
      step_r <= cfg_data;
    end
  end

  assign in_tready = eng_idle;

  stp_engine u_engine (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (in_tvalid && in_tready),
    .action      (in_tuser),
    .sample      (in_tdata[SAMPLE_W-1:0]),
    .point_index (in_tdata[SAMPLE_W +: POINT_W]),
    .point_step  (step_r),
    .idle        (eng_idle),
    .wr_en       (wr_en),
    .wr_data     (wr_data),
    .rd_en       (rd_en),
    .rd_addr     (rd_addr),
    .rd_data     (rd_data),
    .res_valid   (res_valid),
    .res_ready   (res_ready),
    .res         (res)
  );

  stp_store u_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (wr_en),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign res_ready = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= res_valid;
    end
    if (res_ready && res_valid) begin
      out_r <= res;
    end
  end

  assign out_tvalid   = out_valid_r;
  assign out_tuser[0] = out_r.kind;
  assign out_tdata    = {5'd0, out_r.row, out_r.edge_found, out_r.trig_pos};

endmodule
